### hw/rtl/vertex_normal_accumulator_macros.svh
`ifndef VERTEX_NORMAL_ACCUMULATOR_MACROS_SVH
`define VERTEX_NORMAL_ACCUMULATOR_MACROS_SVH

// same-cycle implication, disabled in reset
`define VNA_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled in reset
`define VNA_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/vna_pkg.sv
package vna_pkg;

    localparam int MAX_VERTICES = 1024;
    localparam int ADDR_W       = $clog2(MAX_VERTICES);
    localparam int COUNT_W      = 11;
    localparam int COORD_BITS   = 16;
    localparam int SUM_BITS     = 48;
    localparam int SUMX_W       = SUM_BITS + 1;
    localparam int DIFF_W       = COORD_BITS + 1;
    localparam int PROD_W       = 2 * DIFF_W;
    localparam int NRM_W        = PROD_W + 1;
    localparam int POS_W        = 3 * COORD_BITS;
    localparam int SUMS_W       = 3 * SUM_BITS;
    localparam int NORM_BITS    = 16;
    localparam int SQ_W         = 2 * NORM_BITS;
    localparam int LEN_W        = NORM_BITS;
    localparam int T_W          = LEN_W + 1;
    localparam int NUM_W        = T_W + 8;
    localparam int QDEPTH       = 2;
    localparam int QP_W         = $clog2(QDEPTH);
    localparam int QC_W         = $clog2(QDEPTH + 1);

    localparam logic [7:0] ALPHA_BYTE = 8'hFF;
    localparam logic [7:0] ZERO_BYTE  = 8'h7F;

    typedef enum logic [1:0] {
        OP_CLEAR = 2'd0,
        OP_WRITE = 2'd1,
        OP_TRI   = 2'd2,
        OP_READ  = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_SKIP  = 2'd1,
        ST_RANGE = 2'd2
    } t_status;

    typedef enum logic [4:0] {
        S_INIT,
        S_IDLE,
        S_CLR,
        S_TRA,
        S_TRB,
        S_TRC,
        S_TRE,
        S_MUL,
        S_CRD,
        S_CWR,
        S_RRD,
        S_RWAIT,
        S_SHIFT,
        S_SQ,
        S_SQRT,
        S_DINIT,
        S_DIV,
        S_RES
    } t_bstate;

    typedef struct packed {
        t_op                          op;
        t_status                      status;
        logic signed [COORD_BITS-1:0] x;
        logic signed [COORD_BITS-1:0] y;
        logic signed [COORD_BITS-1:0] z;
        logic [ADDR_W-1:0]            a;
        logic [ADDR_W-1:0]            b;
        logic [ADDR_W-1:0]            c;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    typedef struct packed {
        logic init_busy;
        logic idle;
    } t_back_stat;

endpackage

### hw/rtl/vna_ram.sv
module vna_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

### hw/rtl/vna_front.sv
module vna_front (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [vna_pkg::COUNT_W-1:0]        i_cfg_data,
    input  logic                               i_valid,
    input  logic [1:0]                         i_opcode,
    input  logic signed [vna_pkg::COORD_BITS-1:0] i_vertex_x,
    input  logic signed [vna_pkg::COORD_BITS-1:0] i_vertex_y,
    input  logic signed [vna_pkg::COORD_BITS-1:0] i_vertex_z,
    input  logic [vna_pkg::ADDR_W-1:0]         i_corner_a,
    input  logic [vna_pkg::ADDR_W-1:0]         i_corner_b,
    input  logic [vna_pkg::ADDR_W-1:0]         i_corner_c,
    input  vna_pkg::t_q_stat                   i_q_stat,
    input  vna_pkg::t_back_stat                i_b_stat,
    output logic                               o_ready,
    output logic                               o_push,
    output vna_pkg::t_cmd                      o_cmd
);
    import vna_pkg::*;

    logic [COUNT_W-1:0] r_vertex_count;
    logic [COUNT_W-1:0] count_eff;
    logic               a_ok;
    logic               b_ok;
    logic               c_ok;
    t_op                op;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vertex_count <= '0;
        end else if (i_cfg_we) begin
            r_vertex_count <= i_cfg_data;
        end
    end

    always_comb begin
        count_eff = (r_vertex_count > COUNT_W'(MAX_VERTICES)) ? COUNT_W'(MAX_VERTICES)
                                                              : r_vertex_count;
        a_ok      = COUNT_W'(i_corner_a) < count_eff;
        b_ok      = COUNT_W'(i_corner_b) < count_eff;
        c_ok      = COUNT_W'(i_corner_c) < count_eff;
        op        = t_op'(i_opcode);
        o_cmd.op  = op;
        o_cmd.x   = i_vertex_x;
        o_cmd.y   = i_vertex_y;
        o_cmd.z   = i_vertex_z;
        o_cmd.a   = i_corner_a;
        o_cmd.b   = i_corner_b;
        o_cmd.c   = i_corner_c;
        unique case (op)
            OP_CLEAR: o_cmd.status = ST_DONE;
            OP_TRI:   o_cmd.status = (a_ok && b_ok && c_ok) ? ST_DONE : ST_SKIP;
            default:  o_cmd.status = a_ok ? ST_DONE : ST_RANGE;
        endcase
    end

    assign o_ready = !i_q_stat.full && !i_b_stat.init_busy;
    assign o_push  = i_valid && o_ready;
endmodule

### hw/rtl/vna_queue.sv
`include "vertex_normal_accumulator_macros.svh"

module vna_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  vna_pkg::t_cmd    i_cmd,
    input  logic             i_pop,
    output vna_pkg::t_cmd    o_head,
    output vna_pkg::t_q_stat o_stat
);
    import vna_pkg::*;

    t_cmd            r_slot [QDEPTH];
    logic [QP_W-1:0] r_wp;
    logic [QP_W-1:0] r_rp;
    logic [QC_W-1:0] r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == QP_W'(QDEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= (r_rp == QP_W'(QDEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wp] <= i_cmd;
        end
    end

    assign o_head       = r_slot[r_rp];
    assign o_stat.full  = r_cnt == QC_W'(QDEPTH);
    assign o_stat.empty = r_cnt == '0;

    `VNA_ASSERT_IMP(a_no_overflow, i_clk, i_rst_n, i_push, r_cnt != QC_W'(QDEPTH), "queue overflow")
    `VNA_ASSERT_IMP(a_no_underflow, i_clk, i_rst_n, i_pop, r_cnt != '0, "queue underflow")
    `VNA_ASSERT_NXT(a_cnt_track, i_clk, i_rst_n, i_push && !i_pop, r_cnt != '0, "count lost a beat")
endmodule

### hw/rtl/vna_back.sv
`include "vertex_normal_accumulator_macros.svh"

module vna_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  vna_pkg::t_q_stat    i_q_stat,
    input  vna_pkg::t_cmd       i_head,
    output logic                o_pop,
    output vna_pkg::t_back_stat o_stat,
    input  logic                i_ready,
    output logic                o_valid,
    output logic [31:0]         o_packed_normal,
    output logic [1:0]          o_status
);
    import vna_pkg::*;

    function automatic logic signed [DIFF_W-1:0] f_diff(
        input logic signed [COORD_BITS-1:0] p,
        input logic signed [COORD_BITS-1:0] q
    );
        return DIFF_W'(p) - DIFF_W'(q);
    endfunction

    function automatic logic [SUM_BITS-1:0] f_sat(
        input logic signed [SUM_BITS-1:0] s,
        input logic signed [NRM_W-1:0]    n
    );
        logic signed [SUMX_W-1:0] t;
        t = SUMX_W'(s) + SUMX_W'(n);
        if (t[SUM_BITS] != t[SUM_BITS-1]) begin
            return t[SUM_BITS] ? {1'b1, {(SUM_BITS-1){1'b0}}} : {1'b0, {(SUM_BITS-1){1'b1}}};
        end
        return t[SUM_BITS-1:0];
    endfunction

    function automatic logic f_fits(input logic signed [SUM_BITS-1:0] v);
        return (&v[SUM_BITS-1:NORM_BITS-1]) || !(|v[SUM_BITS-1:NORM_BITS-1]);
    endfunction

    t_bstate                    r_state, n_state;
    t_cmd                       r_cmd, n_cmd;
    logic signed [COORD_BITS-1:0] r_p0 [3], n_p0 [3];
    logic signed [DIFF_W-1:0]   r_e1 [3], n_e1 [3];
    logic signed [DIFF_W-1:0]   r_e2 [3], n_e2 [3];
    logic signed [PROD_W-1:0]   r_prod, n_prod;
    logic signed [NRM_W-1:0]    r_n [3], n_n [3];
    logic signed [SUM_BITS-1:0] r_v [3], n_v [3];
    logic [2:0]                 r_step, n_step;
    logic [1:0]                 r_ci, n_ci;
    logic [ADDR_W-1:0]          r_addr, n_addr;
    logic [SQ_W-1:0]            r_sq, n_sq;
    logic [SQ_W-1:0]            r_root, n_root;
    logic [SQ_W-1:0]            r_bit, n_bit;
    logic [NUM_W-1:0]           r_rem, n_rem;
    logic [7:0]                 r_q, n_q;
    logic [7:0]                 r_bytes [3], n_bytes [3];
    logic                       r_ovalid, n_ovalid;
    logic [31:0]                r_opacked, n_opacked;
    logic [1:0]                 r_ostatus, n_ostatus;

    logic                       pos_we;
    logic [ADDR_W-1:0]          pos_waddr;
    logic [ADDR_W-1:0]          pos_raddr;
    logic [POS_W-1:0]           pos_wdata;
    logic [POS_W-1:0]           pos_rdata;
    logic                       sum_we;
    logic [ADDR_W-1:0]          sum_waddr;
    logic [ADDR_W-1:0]          sum_raddr;
    logic [SUMS_W-1:0]          sum_wdata;
    logic [SUMS_W-1:0]          sum_rdata;

    logic signed [COORD_BITS-1:0] pos_c [3];
    logic signed [SUM_BITS-1:0]   sum_c [3];
    logic [ADDR_W-1:0]          corner;
    logic [1:0]                 sel;
    logic signed [NORM_BITS-1:0] cs;
    logic signed [SQ_W-1:0]     sqp;
    logic [T_W-1:0]             tsum;
    logic [NUM_W-1:0]           dsh;
    logic [SQ_W-1:0]            trial;
    logic [1:0]                 i1, i2, comp;
    logic [2:0]                 km1;
    logic                       all_fit;

    vna_ram #(.WIDTH(POS_W), .DEPTH(MAX_VERTICES)) u_pos_ram (
        .i_clk   (i_clk),
        .i_we    (pos_we),
        .i_waddr (pos_waddr),
        .i_wdata (pos_wdata),
        .i_raddr (pos_raddr),
        .o_rdata (pos_rdata)
    );

    vna_ram #(.WIDTH(SUMS_W), .DEPTH(MAX_VERTICES)) u_sum_ram (
        .i_clk   (i_clk),
        .i_we    (sum_we),
        .i_waddr (sum_waddr),
        .i_wdata (sum_wdata),
        .i_raddr (sum_raddr),
        .o_rdata (sum_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_INIT;
            r_addr   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_addr   <= n_addr;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd     <= n_cmd;
        r_p0      <= n_p0;
        r_e1      <= n_e1;
        r_e2      <= n_e2;
        r_prod    <= n_prod;
        r_n       <= n_n;
        r_v       <= n_v;
        r_step    <= n_step;
        r_ci      <= n_ci;
        r_sq      <= n_sq;
        r_root    <= n_root;
        r_bit     <= n_bit;
        r_rem     <= n_rem;
        r_q       <= n_q;
        r_bytes   <= n_bytes;
        r_opacked <= n_opacked;
        r_ostatus <= n_ostatus;
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            pos_c[i] = pos_rdata[POS_W-1-i*COORD_BITS -: COORD_BITS];
            sum_c[i] = sum_rdata[SUMS_W-1-i*SUM_BITS -: SUM_BITS];
        end
        unique case (r_ci)
            2'd0:    corner = r_cmd.a;
            2'd1:    corner = r_cmd.b;
            default: corner = r_cmd.c;
        endcase
        sel     = (r_state == S_SQ) ? r_step[1:0] : r_ci;
        cs      = r_v[sel][NORM_BITS-1:0];
        sqp     = cs * cs;
        tsum    = T_W'(cs) + T_W'(r_root[LEN_W-1:0]);
        dsh     = NUM_W'({r_root[LEN_W-1:0], 1'b0}) << r_step;
        trial   = r_root + r_bit;
        all_fit = f_fits(r_v[0]) && f_fits(r_v[1]) && f_fits(r_v[2]);
        km1     = r_step - 3'd1;
        comp    = km1[2:1];
        unique case (r_step)
            3'd0:    begin i1 = 2'd1; i2 = 2'd2; end
            3'd1:    begin i1 = 2'd2; i2 = 2'd1; end
            3'd2:    begin i1 = 2'd2; i2 = 2'd0; end
            3'd3:    begin i1 = 2'd0; i2 = 2'd2; end
            3'd4:    begin i1 = 2'd0; i2 = 2'd1; end
            default: begin i1 = 2'd1; i2 = 2'd0; end
        endcase
    end

    always_comb begin
        n_state   = r_state;
        n_cmd     = r_cmd;
        n_p0      = r_p0;
        n_e1      = r_e1;
        n_e2      = r_e2;
        n_prod    = r_prod;
        n_n       = r_n;
        n_v       = r_v;
        n_step    = r_step;
        n_ci      = r_ci;
        n_addr    = r_addr;
        n_sq      = r_sq;
        n_root    = r_root;
        n_bit     = r_bit;
        n_rem     = r_rem;
        n_q       = r_q;
        n_bytes   = r_bytes;
        n_ovalid  = r_ovalid && !i_ready;
        n_opacked = r_opacked;
        n_ostatus = r_ostatus;
        o_pop     = 1'b0;
        pos_we    = 1'b0;
        pos_waddr = i_head.a;
        pos_wdata = {i_head.x, i_head.y, i_head.z};
        pos_raddr = r_cmd.a;
        sum_we    = 1'b0;
        sum_waddr = r_addr;
        sum_wdata = '0;
        sum_raddr = r_cmd.a;

        unique case (r_state)
            S_INIT, S_CLR: begin
                sum_we = 1'b1;
                n_addr = r_addr + 1'b1;
                if (r_addr == ADDR_W'(MAX_VERTICES - 1)) begin
                    n_state = (r_state == S_INIT) ? S_IDLE : S_RES;
                end
            end
            S_IDLE: begin
                if (!i_q_stat.empty) begin
                    o_pop = 1'b1;
                    n_cmd = i_head;
                    if (i_head.status != ST_DONE) begin
                        n_state = S_RES;
                    end else begin
                        unique case (i_head.op)
                            OP_CLEAR: begin
                                n_addr  = '0;
                                n_state = S_CLR;
                            end
                            OP_WRITE: begin
                                pos_we  = 1'b1;
                                n_state = S_RES;
                            end
                            OP_TRI:  n_state = S_TRA;
                            default: n_state = S_RRD;
                        endcase
                    end
                end
            end
            S_TRA: begin
                pos_raddr = r_cmd.a;
                n_state   = S_TRB;
            end
            S_TRB: begin
                pos_raddr = r_cmd.b;
                n_p0      = pos_c;
                n_state   = S_TRC;
            end
            S_TRC: begin
                pos_raddr = r_cmd.c;
                for (int i = 0; i < 3; i++) begin
                    n_e1[i] = f_diff(pos_c[i], r_p0[i]);
                end
                n_state = S_TRE;
            end
            S_TRE: begin
                for (int i = 0; i < 3; i++) begin
                    n_e2[i] = f_diff(pos_c[i], r_p0[i]);
                end
                n_step  = '0;
                n_state = S_MUL;
            end
            S_MUL: begin
                if (r_step != 3'd6) begin
                    n_prod = r_e1[i1] * r_e2[i2];
                end
                if (r_step != 3'd0) begin
                    if (!km1[0]) begin
                        n_n[comp] = NRM_W'(r_prod);
                    end else begin
                        n_n[comp] = r_n[comp] - NRM_W'(r_prod);
                    end
                end
                n_step = r_step + 3'd1;
                if (r_step == 3'd6) begin
                    n_ci    = '0;
                    n_state = S_CRD;
                end
            end
            S_CRD: begin
                sum_raddr = corner;
                n_state   = S_CWR;
            end
            S_CWR: begin
                sum_we    = 1'b1;
                sum_waddr = corner;
                sum_wdata = {f_sat(sum_c[0], r_n[0]), f_sat(sum_c[1], r_n[1]),
                             f_sat(sum_c[2], r_n[2])};
                n_ci      = r_ci + 2'd1;
                n_state   = (r_ci == 2'd2) ? S_RES : S_CRD;
            end
            S_RRD: begin
                sum_raddr = r_cmd.a;
                n_state   = S_RWAIT;
            end
            S_RWAIT: begin
                n_v = sum_c;
                if (sum_rdata == '0) begin
                    for (int i = 0; i < 3; i++) begin
                        n_bytes[i] = ZERO_BYTE;
                    end
                    n_state = S_RES;
                end else begin
                    n_state = S_SHIFT;
                end
            end
            S_SHIFT: begin
                if (all_fit) begin
                    n_sq    = '0;
                    n_step  = '0;
                    n_state = S_SQ;
                end else begin
                    for (int i = 0; i < 3; i++) begin
                        n_v[i] = r_v[i] >>> 1;
                    end
                end
            end
            S_SQ: begin
                n_sq   = r_sq + SQ_W'(unsigned'(sqp));
                n_step = r_step + 3'd1;
                if (r_step == 3'd2) begin
                    n_root  = '0;
                    n_bit   = SQ_W'(1) << (SQ_W - 2);
                    n_state = S_SQRT;
                end
            end
            S_SQRT: begin
                if (r_sq >= trial) begin
                    n_sq   = r_sq - trial;
                    n_root = (r_root >> 1) + r_bit;
                end else begin
                    n_root = r_root >> 1;
                end
                n_bit = r_bit >> 2;
                if (r_bit == SQ_W'(1)) begin
                    n_ci    = '0;
                    n_state = S_DINIT;
                end
            end
            S_DINIT: begin
                if (r_root[LEN_W-1:0] == '0) begin
                    for (int i = 0; i < 3; i++) begin
                        n_bytes[i] = ZERO_BYTE;
                    end
                    n_state = S_RES;
                end else begin
                    n_rem   = NUM_W'({tsum, 8'b0}) - NUM_W'(tsum);
                    n_q     = '0;
                    n_step  = 3'd7;
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                if (r_rem >= dsh) begin
                    n_rem = r_rem - dsh;
                    n_q   = {r_q[6:0], 1'b1};
                end else begin
                    n_q   = {r_q[6:0], 1'b0};
                end
                n_step = r_step - 3'd1;
                if (r_step == 3'd0) begin
                    n_bytes[r_ci] = n_q;
                    n_ci          = r_ci + 2'd1;
                    n_state       = (r_ci == 2'd2) ? S_RES : S_DINIT;
                end
            end
            S_RES: begin
                if (!r_ovalid || i_ready) begin
                    n_ovalid  = 1'b1;
                    n_ostatus = r_cmd.status;
                    if (r_cmd.op == OP_READ && r_cmd.status == ST_DONE) begin
                        n_opacked = {ALPHA_BYTE, r_bytes[2], r_bytes[1], r_bytes[0]};
                    end else begin
                        n_opacked = '0;
                    end
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_stat.init_busy = r_state == S_INIT;
    assign o_stat.idle      = r_state == S_IDLE;
    assign o_valid          = r_ovalid;
    assign o_packed_normal  = r_opacked;
    assign o_status         = r_ostatus;

    `VNA_ASSERT_NXT(a_res_holds, i_clk, i_rst_n, r_state == S_RES && r_ovalid && !i_ready, r_state == S_RES, "result left while output busy")
    `VNA_ASSERT_IMP(a_corner_idx, i_clk, i_rst_n, r_state == S_CWR || r_state == S_CRD, r_ci != 2'd3, "corner index out of range")
    `VNA_ASSERT_NXT(a_div_end, i_clk, i_rst_n, r_state == S_DIV && r_step == 3'd0 && r_ci == 2'd2, r_state == S_RES, "division did not finish")
endmodule

### hw/rtl/vertex_normal_accumulator.sv
// channel | valid   | ready   | payload
// in      | i_valid | o_ready | i_opcode, i_vertex_x/y/z, i_corner_a/b/c
// out     | o_valid | i_ready | o_packed_normal, o_status
// cfg     | i_cfg_we| -       | i_cfg_data (vertex_count)
// steps per item, set by the back-end sequencer and its registered-read memories:
// write or rejected item: result only; triangle: three position reads, six products,
// three sum read-modify-writes; read of a zero sum: sum read, result; other reads:
// shift steps, squares, root, three divisions on one divider
// clear writes one sum row per cycle; after reset a clearing pass over all sum rows
// runs and o_ready stays low; a two-beat queue lets input beats land while the back
// end works or the output register stalls
module vertex_normal_accumulator (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_we,
    input  logic [vna_pkg::COUNT_W-1:0]           i_cfg_data,
    input  logic                                  i_valid,
    output logic                                  o_ready,
    input  logic [1:0]                            i_opcode,
    input  logic signed [vna_pkg::COORD_BITS-1:0] i_vertex_x,
    input  logic signed [vna_pkg::COORD_BITS-1:0] i_vertex_y,
    input  logic signed [vna_pkg::COORD_BITS-1:0] i_vertex_z,
    input  logic [vna_pkg::ADDR_W-1:0]            i_corner_a,
    input  logic [vna_pkg::ADDR_W-1:0]            i_corner_b,
    input  logic [vna_pkg::ADDR_W-1:0]            i_corner_c,
    output logic                                  o_valid,
    input  logic                                  i_ready,
    output logic [31:0]                           o_packed_normal,
    output logic [1:0]                            o_status
);
    import vna_pkg::*;

    logic       push;
    logic       pop;
    t_cmd       cmd;
    t_cmd       head;
    t_q_stat    q_stat;
    t_back_stat b_stat;

    vna_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_valid    (i_valid),
        .i_opcode   (i_opcode),
        .i_vertex_x (i_vertex_x),
        .i_vertex_y (i_vertex_y),
        .i_vertex_z (i_vertex_z),
        .i_corner_a (i_corner_a),
        .i_corner_b (i_corner_b),
        .i_corner_c (i_corner_c),
        .i_q_stat   (q_stat),
        .i_b_stat   (b_stat),
        .o_ready    (o_ready),
        .o_push     (push),
        .o_cmd      (cmd)
    );

    vna_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (cmd),
        .i_pop   (pop),
        .o_head  (head),
        .o_stat  (q_stat)
    );

    vna_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_q_stat        (q_stat),
        .i_head          (head),
        .o_pop           (pop),
        .o_stat          (b_stat),
        .i_ready         (i_ready),
        .o_valid         (o_valid),
        .o_packed_normal (o_packed_normal),
        .o_status        (o_status)
    );
endmodule

### dv/tb.sv
`timescale 1ns / 100ps

module tb;
    import vna_pkg::*;

    typedef struct {
        t_op                          op;
        logic signed [COORD_BITS-1:0] x;
        logic signed [COORD_BITS-1:0] y;
        logic signed [COORD_BITS-1:0] z;
        logic [ADDR_W-1:0]            a;
        logic [ADDR_W-1:0]            b;
        logic [ADDR_W-1:0]            c;
    } t_tb_cmd;

    typedef struct {
        logic [31:0] normal;
        t_status     st;
    } t_tb_res;

    localparam int STALL_LIMIT = 6000;
    localparam longint SUM_MAX = (64'sd1 <<< (SUM_BITS - 1)) - 1;
    localparam longint SUM_MIN = -SUM_MAX - 1;

    logic                         clk = 0;
    logic                         rst_n = 0;
    logic                         cfg_we = 0;
    logic [COUNT_W-1:0]           cfg_data = '0;
    logic                         vld = 0;
    logic                         o_ready;
    logic [1:0]                   opcode = '0;
    logic signed [COORD_BITS-1:0] vx = '0, vy = '0, vz = '0;
    logic [ADDR_W-1:0]            ca = '0, cb = '0, cc = '0;
    logic                         o_valid;
    logic                         rdy = 0;
    logic [31:0]                  o_packed_normal;
    logic [1:0]                   o_status;

    t_tb_cmd  cmd_queue[$];
    t_tb_res  normal_queue[$];
    logic     took = 0;
    logic     quiet = 0;
    int       in_gap = 0, out_gap = 0;
    int       errors = 0, beats_in = 0, beats_out = 0, reads_ok = 0;
    int       stall_cycles = 0;

    // predictor state
    int unsigned vcount = 0;
    int          pos_x[MAX_VERTICES], pos_y[MAX_VERTICES], pos_z[MAX_VERTICES];
    longint      sum_x[MAX_VERTICES], sum_y[MAX_VERTICES], sum_z[MAX_VERTICES];

    // generator view of which positions hold data
    int unsigned gen_count = 0;
    bit          gen_written[MAX_VERTICES];

    vertex_normal_accumulator dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_data      (cfg_data),
        .i_valid         (vld),
        .o_ready         (o_ready),
        .i_opcode        (opcode),
        .i_vertex_x      (vx),
        .i_vertex_y      (vy),
        .i_vertex_z      (vz),
        .i_corner_a      (ca),
        .i_corner_b      (cb),
        .i_corner_c      (cc),
        .o_valid         (o_valid),
        .i_ready         (rdy),
        .o_packed_normal (o_packed_normal),
        .o_status        (o_status)
    );

    always #5 clk = ~clk;

    function automatic longint sat_sum(longint s, longint d);
        longint r;
        r = s + d;
        if (r > SUM_MAX) r = SUM_MAX;
        if (r < SUM_MIN) r = SUM_MIN;
        return r;
    endfunction

    function automatic bit fits_short(longint v);
        return v >= -32768 && v <= 32767;
    endfunction

    function automatic longint int_root(longint unsigned n);
        longint unsigned r, bitv;
        r = 0;
        bitv = 64'd1 << 62;
        while (bitv > n) bitv >>= 2;
        while (bitv != 0) begin
            if (n >= r + bitv) begin
                n = n - (r + bitv);
                r = (r >> 1) + bitv;
            end else begin
                r >>= 1;
            end
            bitv >>= 2;
        end
        return r;
    endfunction

    function automatic logic [7:0] norm_byte(longint c, longint len);
        longint q;
        q = ((c + len) * 255) / (2 * len);
        if (q > 255) q = 255;
        return q[7:0];
    endfunction

    function automatic logic [31:0] normal_rgba(int idx);
        longint x, y, z, len;
        int s;
        x = sum_x[idx];
        y = sum_y[idx];
        z = sum_z[idx];
        if (x == 0 && y == 0 && z == 0) return {ALPHA_BYTE, {3{ZERO_BYTE}}};
        s = 0;
        while (s < 63 && !(fits_short(x >>> s) && fits_short(y >>> s) && fits_short(z >>> s)))
            s++;
        x = x >>> s;
        y = y >>> s;
        z = z >>> s;
        len = int_root(x * x + y * y + z * z);
        if (len == 0) return {ALPHA_BYTE, {3{ZERO_BYTE}}};
        return {ALPHA_BYTE, norm_byte(z, len), norm_byte(y, len), norm_byte(x, len)};
    endfunction

    function automatic t_tb_res accumulate(t_tb_cmd cmd);
        t_tb_res r;
        int unsigned lim;
        longint e1x, e1y, e1z, e2x, e2y, e2z, nx, ny, nz;
        int k[3];
        r.normal = '0;
        r.st = ST_DONE;
        lim = (vcount < MAX_VERTICES) ? vcount : MAX_VERTICES;
        case (cmd.op)
            OP_CLEAR: begin
                for (int i = 0; i < MAX_VERTICES; i++) begin
                    sum_x[i] = 0;
                    sum_y[i] = 0;
                    sum_z[i] = 0;
                end
            end
            OP_WRITE: begin
                if (cmd.a >= lim) r.st = ST_RANGE;
                else begin
                    pos_x[cmd.a] = cmd.x;
                    pos_y[cmd.a] = cmd.y;
                    pos_z[cmd.a] = cmd.z;
                end
            end
            OP_TRI: begin
                if (cmd.a >= lim || cmd.b >= lim || cmd.c >= lim) r.st = ST_SKIP;
                else begin
                    e1x = pos_x[cmd.b] - pos_x[cmd.a];
                    e1y = pos_y[cmd.b] - pos_y[cmd.a];
                    e1z = pos_z[cmd.b] - pos_z[cmd.a];
                    e2x = pos_x[cmd.c] - pos_x[cmd.a];
                    e2y = pos_y[cmd.c] - pos_y[cmd.a];
                    e2z = pos_z[cmd.c] - pos_z[cmd.a];
                    nx = e1y * e2z - e1z * e2y;
                    ny = e1z * e2x - e1x * e2z;
                    nz = e1x * e2y - e1y * e2x;
                    k[0] = cmd.a;
                    k[1] = cmd.b;
                    k[2] = cmd.c;
                    for (int i = 0; i < 3; i++) begin
                        sum_x[k[i]] = sat_sum(sum_x[k[i]], nx);
                        sum_y[k[i]] = sat_sum(sum_y[k[i]], ny);
                        sum_z[k[i]] = sat_sum(sum_z[k[i]], nz);
                    end
                end
            end
            default: begin
                if (cmd.a >= lim) r.st = ST_RANGE;
                else r.normal = normal_rgba(cmd.a);
            end
        endcase
        return r;
    endfunction

    // predictor and checker
    always @(posedge clk) begin
        t_tb_cmd cmd;
        t_tb_res want;
        bit in_fire, out_fire;
        in_fire = (vld === 1'b1) && (o_ready === 1'b1);
        out_fire = (o_valid === 1'b1) && rdy;
        took <= in_fire;
        if (cfg_we) vcount = cfg_data;
        if (in_fire) begin
            cmd.op = t_op'(opcode);
            cmd.x = vx;
            cmd.y = vy;
            cmd.z = vz;
            cmd.a = ca;
            cmd.b = cb;
            cmd.c = cc;
            normal_queue = {normal_queue, accumulate(cmd)};
            beats_in++;
        end
        if (out_fire) begin
            beats_out++;
            if (normal_queue.size() == 0) begin
                $display("%0t: result beat with nothing expected: normal %h status %0d",
                         $time, o_packed_normal, o_status);
                errors++;
            end else begin
                want = normal_queue.pop_front();
                if (o_packed_normal !== want.normal) begin
                    $display("%0t: packed_normal expected %h actual %h",
                             $time, want.normal, o_packed_normal);
                    errors++;
                end
                if (o_status !== want.st) begin
                    $display("%0t: status expected %0d actual %0d", $time, want.st, o_status);
                    errors++;
                end
                if (want.st == ST_DONE && want.normal != 0) reads_ok++;
            end
        end
        if (in_fire || out_fire || (cmd_queue.size() == 0 && !vld && normal_queue.size() == 0))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("%0t: no beat for %0d cycles", $time, STALL_LIMIT);
            $display("Test completed with failures");
            $finish;
        end
    end

    // input driver
    always @(negedge clk) begin
        t_tb_cmd cmd;
        if (rst_n && (!vld || took)) begin
            if (in_gap > 0) begin
                in_gap--;
                vld <= 1'b0;
            end else if (!quiet && $urandom_range(9) == 0) begin
                in_gap = $urandom_range(15);
                vld <= 1'b0;
            end else if (cmd_queue.size() > 0) begin
                cmd = cmd_queue.pop_front();
                vld <= 1'b1;
                opcode <= cmd.op;
                vx <= cmd.x;
                vy <= cmd.y;
                vz <= cmd.z;
                ca <= cmd.a;
                cb <= cmd.b;
                cc <= cmd.c;
            end else begin
                vld <= 1'b0;
            end
        end
    end

    // result-side stalls
    always @(negedge clk) begin
        if (out_gap > 0) begin
            out_gap--;
            rdy <= 1'b0;
        end else if (!quiet && $urandom_range(9) == 0) begin
            out_gap = $urandom_range(15);
            rdy <= 1'b0;
        end else begin
            rdy <= 1'b1;
        end
    end

    function automatic logic signed [15:0] rand_coord();
        if ($urandom_range(1)) return COORD_BITS'(int'($urandom_range(600)) - 300);
        return COORD_BITS'($urandom);
    endfunction

    function automatic logic [ADDR_W-1:0] rand_addr();
        return ADDR_W'($urandom);
    endfunction

    task automatic push_cmd(t_op op, logic [ADDR_W-1:0] a, logic [ADDR_W-1:0] b,
                            logic [ADDR_W-1:0] c, logic signed [15:0] x,
                            logic signed [15:0] y, logic signed [15:0] z);
        t_tb_cmd cmd;
        cmd.op = op;
        cmd.a = a;
        cmd.b = b;
        cmd.c = c;
        cmd.x = x;
        cmd.y = y;
        cmd.z = z;
        if (op == OP_WRITE && a < gen_count) gen_written[a] = 1;
        cmd_queue = {cmd_queue, cmd};
    endtask

    task automatic push_random(int n);
        int lim, pick;
        int live[$];
        logic [ADDR_W-1:0] k[3];
        lim = (gen_count < MAX_VERTICES) ? gen_count : MAX_VERTICES;
        for (int i = 0; i < n; i++) begin
            live.delete();
            for (int v = 0; v < lim; v++) if (gen_written[v]) live = {live, v};
            pick = $urandom_range(99);
            if (pick < 2) begin
                push_cmd(OP_CLEAR, rand_addr(), rand_addr(), rand_addr(), rand_coord(),
                         rand_coord(), rand_coord());
            end else if (pick < 60 && live.size() > 0) begin
                for (int j = 0; j < 3; j++)
                    k[j] = ADDR_W'(live[$urandom_range(live.size() - 1)]);
                if (lim < MAX_VERTICES && $urandom_range(9) == 0)
                    k[$urandom_range(2)] = ADDR_W'($urandom_range(MAX_VERTICES - 1, lim));
                push_cmd(OP_TRI, k[0], k[1], k[2], rand_coord(), rand_coord(), rand_coord());
            end else if (pick < 80 && lim > 0) begin
                k[0] = (lim < MAX_VERTICES && $urandom_range(9) == 0) ?
                       ADDR_W'($urandom_range(MAX_VERTICES - 1, lim)) :
                       ADDR_W'($urandom_range(lim - 1));
                push_cmd(OP_READ, k[0], rand_addr(), rand_addr(), rand_coord(), rand_coord(),
                         rand_coord());
            end else begin
                k[0] = (lim == 0 || (lim < MAX_VERTICES && $urandom_range(9) == 0)) ?
                       ADDR_W'($urandom_range(MAX_VERTICES - 1, lim)) :
                       ADDR_W'($urandom_range(lim - 1));
                push_cmd(OP_WRITE, k[0], rand_addr(), rand_addr(), rand_coord(), rand_coord(),
                         rand_coord());
            end
        end
    endtask

    task automatic drain();
        while (cmd_queue.size() > 0 || vld || normal_queue.size() > 0) @(posedge clk);
        repeat (200) @(posedge clk);
    endtask

    task automatic set_count(int unsigned n);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_data <= COUNT_W'(n);
        gen_count = n;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    initial begin
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // no vertices in use: write and read rejected, triangle skipped, clear still done
        set_count(0);
        push_cmd(OP_WRITE, 0, 0, 0, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
        push_cmd(OP_READ, 0, 0, 0, 0, 0, 0);
        push_cmd(OP_TRI, 0, 0, 0, 0, 0, 0);
        push_cmd(OP_CLEAR, 0, 0, 0, 0, 0, 0);
        drain();

        // count beyond the table, clamped to full size
        set_count(2047);
        push_cmd(OP_WRITE, 0, 0, 0, -16'sd32768, -16'sd32768, -16'sd32768);
        push_cmd(OP_WRITE, 1, 0, 0, 16'sh7FFF, -16'sd32768, 16'sh7FFF);
        push_cmd(OP_WRITE, 2, 0, 0, -16'sd32768, 16'sh7FFF, 16'sh7FFF);
        push_cmd(OP_WRITE, 1023, 1023, 1023, -16'sd1, -16'sd1, -16'sd1);
        push_cmd(OP_READ, 5, 0, 0, 0, 0, 0);
        push_cmd(OP_TRI, 0, 1, 2, 0, 0, 0);
        push_cmd(OP_TRI, 0, 1, 2, 0, 0, 0);
        push_cmd(OP_TRI, 2, 2, 1023, 0, 0, 0);
        push_cmd(OP_TRI, 1023, 0, 0, 0, 0, 0);
        push_cmd(OP_READ, 0, 0, 0, 0, 0, 0);
        push_cmd(OP_READ, 2, 0, 0, 0, 0, 0);
        push_cmd(OP_READ, 1023, 0, 0, 0, 0, 0);
        push_cmd(OP_CLEAR, 1023, 1023, 1023, -16'sd1, -16'sd1, -16'sd1);
        push_cmd(OP_READ, 0, 0, 0, 0, 0, 0);
        push_random(120);
        drain();

        // tiny table with many out-of-range corners
        set_count(3);
        push_cmd(OP_TRI, 0, 1, 3, 0, 0, 0);
        push_cmd(OP_WRITE, 3, 0, 0, 1, 1, 1);
        push_cmd(OP_READ, 3, 0, 0, 0, 0, 0);
        push_random(80);
        drain();

        set_count(1024);
        push_random(100);
        drain();

        // final stretch with no idling on either side
        quiet = 1;
        set_count(40);
        push_random(90);
        drain();

        $display("%0d command beats and %0d result beats, %0d non-zero normals checked",
                 beats_in, beats_out, reads_ok);
        $display("covered vertex counts 0, 3, 40, 1024 and 2047 with clears, skips and range errors");
        if (errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

### filelist.f
+incdir+hw/rtl
hw/rtl/vna_pkg.sv
hw/rtl/vna_ram.sv
hw/rtl/vna_front.sv
hw/rtl/vna_queue.sv
hw/rtl/vna_back.sv
hw/rtl/vertex_normal_accumulator.sv
dv/tb.sv
